@@ rtl/core/obbot_pkg.sv @@
// Shared constants for the oriented box pair overlap test pipeline.
// No dependencies; every other file of the block refers to it by scoped names.
package obbot_pkg;

    localparam int COORD_BITS_DEF = 16;  // default center coordinate width
    localparam int AXIS_W         = 16;  // Q1.14 direction components
    localparam int EXT_W          = 15;  // full box extents
    localparam int DOT_W          = 33;  // signed sum of two axis products
    localparam int ABS_W          = 32;  // magnitude of an axis dot product
    localparam int EP_W           = EXT_W + ABS_W;  // extent times axis dot
    localparam int POS_SHIFT      = 15;  // center scale relative to extents
    localparam int HALF_SHIFT     = 28;  // half extent scale on an axis

endpackage

@@ rtl/core/obbot_if.sv @@
// Valid/ready channels of the box pair overlap test: box pair in, result out.
// Depends on obbot_pkg for field widths.
interface obbot_box_if #(
    parameter int COORD_BITS = obbot_pkg::COORD_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [COORD_BITS-1:0]         a_center_x;
    logic signed [COORD_BITS-1:0]         a_center_y;
    logic signed [obbot_pkg::AXIS_W-1:0]  a_axis_cos;
    logic signed [obbot_pkg::AXIS_W-1:0]  a_axis_sin;
    logic        [obbot_pkg::EXT_W-1:0]   a_width;
    logic        [obbot_pkg::EXT_W-1:0]   a_height;
    logic signed [COORD_BITS-1:0]         b_center_x;
    logic signed [COORD_BITS-1:0]         b_center_y;
    logic signed [obbot_pkg::AXIS_W-1:0]  b_axis_cos;
    logic signed [obbot_pkg::AXIS_W-1:0]  b_axis_sin;
    logic        [obbot_pkg::EXT_W-1:0]   b_width;
    logic        [obbot_pkg::EXT_W-1:0]   b_height;

    modport source (
        output valid, a_center_x, a_center_y, a_axis_cos, a_axis_sin, a_width, a_height,
               b_center_x, b_center_y, b_axis_cos, b_axis_sin, b_width, b_height,
        input  ready
    );
    modport sink (
        input  valid, a_center_x, a_center_y, a_axis_cos, a_axis_sin, a_width, a_height,
               b_center_x, b_center_y, b_axis_cos, b_axis_sin, b_width, b_height,
        output ready
    );
endinterface

interface obbot_res_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink   (input valid, overlap, output ready);
endinterface

@@ rtl/core/obb_pair_overlap_test_unit.sv @@
// Oriented box pair overlap test (separating axis test on four box axes).
// Depends on obbot_pkg, obbot_if, obbot_proj and obbot_sep.
//
// Usage:
//   i_box carries one box pair per request (center, Q1.14 direction, full
//   width and height of each box); o_res returns one overlap bit per pair,
//   1 when no box axis separates them (touching boxes count as overlapping).
//   A request is taken on a clock edge with valid and ready both high.
// Pipeline: six register stages, three in obbot_proj and three in obbot_sep;
//   the result is registered in the last stage before it leaves on o_res.
// Throughput: one pair per cycle unless o_res stalls, set by the six-stage
//   multiply/compare pipeline; pairs share no state, results leave in order.
// Stall: when o_res.ready is low the result holds and stages fill behind it;
//   bubbles close up, and i_box.ready drops only once all six are full.
// Reset: synchronous, active low; empties every stage, no result pending.
module obb_pair_overlap_test_unit #(
    parameter int COORD_BITS = obbot_pkg::COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    obbot_box_if.sink      i_box,
    obbot_res_if.source    o_res
);
    logic                          mid_valid, mid_ready;
    logic [obbot_pkg::ABS_W-1:0]   mid_cc, mid_sc;
    logic [COORD_BITS+16:0]        mid_d_ad, mid_d_ap, mid_d_bd, mid_d_bp;
    logic [obbot_pkg::EXT_W-1:0]   mid_a_w, mid_a_h, mid_b_w, mid_b_h;

    obbot_proj #(.COORD_BITS(COORD_BITS)) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_box.valid),
        .o_ready (i_box.ready),
        .i_a_cx  (i_box.a_center_x),
        .i_a_cy  (i_box.a_center_y),
        .i_a_cos (i_box.a_axis_cos),
        .i_a_sin (i_box.a_axis_sin),
        .i_a_w   (i_box.a_width),
        .i_a_h   (i_box.a_height),
        .i_b_cx  (i_box.b_center_x),
        .i_b_cy  (i_box.b_center_y),
        .i_b_cos (i_box.b_axis_cos),
        .i_b_sin (i_box.b_axis_sin),
        .i_b_w   (i_box.b_width),
        .i_b_h   (i_box.b_height),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_cc    (mid_cc),
        .o_sc    (mid_sc),
        .o_d_ad  (mid_d_ad),
        .o_d_ap  (mid_d_ap),
        .o_d_bd  (mid_d_bd),
        .o_d_bp  (mid_d_bp),
        .o_a_w   (mid_a_w),
        .o_a_h   (mid_a_h),
        .o_b_w   (mid_b_w),
        .o_b_h   (mid_b_h)
    );

    obbot_sep #(.COORD_BITS(COORD_BITS)) u_sep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (mid_valid),
        .o_ready   (mid_ready),
        .i_cc      (mid_cc),
        .i_sc      (mid_sc),
        .i_d_ad    (mid_d_ad),
        .i_d_ap    (mid_d_ap),
        .i_d_bd    (mid_d_bd),
        .i_d_bp    (mid_d_bp),
        .i_a_w     (mid_a_w),
        .i_a_h     (mid_a_h),
        .i_b_w     (mid_b_w),
        .i_b_h     (mid_b_h),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_overlap (o_res.overlap)
    );

endmodule

@@ rtl/core/obbot_proj.sv @@
// First three pipeline stages: center difference, axis products, dot magnitudes.
// Depends on obbot_pkg.
module obbot_proj #(
    parameter int COORD_BITS = obbot_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_BITS-1:0]        i_a_cx,
    input  logic signed [COORD_BITS-1:0]        i_a_cy,
    input  logic signed [obbot_pkg::AXIS_W-1:0] i_a_cos,
    input  logic signed [obbot_pkg::AXIS_W-1:0] i_a_sin,
    input  logic        [obbot_pkg::EXT_W-1:0]  i_a_w,
    input  logic        [obbot_pkg::EXT_W-1:0]  i_a_h,
    input  logic signed [COORD_BITS-1:0]        i_b_cx,
    input  logic signed [COORD_BITS-1:0]        i_b_cy,
    input  logic signed [obbot_pkg::AXIS_W-1:0] i_b_cos,
    input  logic signed [obbot_pkg::AXIS_W-1:0] i_b_sin,
    input  logic        [obbot_pkg::EXT_W-1:0]  i_b_w,
    input  logic        [obbot_pkg::EXT_W-1:0]  i_b_h,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [obbot_pkg::ABS_W-1:0]  o_cc,     // |dirA . dirB|
    output logic        [obbot_pkg::ABS_W-1:0]  o_sc,     // |dirA x dirB|
    output logic        [COORD_BITS+16:0]       o_d_ad,   // |dirA . (cB - cA)|
    output logic        [COORD_BITS+16:0]       o_d_ap,
    output logic        [COORD_BITS+16:0]       o_d_bd,
    output logic        [COORD_BITS+16:0]       o_d_bp,
    output logic        [obbot_pkg::EXT_W-1:0]  o_a_w,
    output logic        [obbot_pkg::EXT_W-1:0]  o_a_h,
    output logic        [obbot_pkg::EXT_W-1:0]  o_b_w,
    output logic        [obbot_pkg::EXT_W-1:0]  o_b_h
);
    localparam int DW = COORD_BITS + 1;   // center difference
    localparam int PW = COORD_BITS + 17;  // axis times difference
    localparam int SW = COORD_BITS + 18;  // sum of two such
    localparam int AW = COORD_BITS + 17;  // magnitude of the sum
    localparam int XW = 2 * obbot_pkg::AXIS_W;
    localparam int EW = obbot_pkg::EXT_W;

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    // stage 1
    logic signed [DW-1:0]                 r_dx, r_dy;
    logic signed [obbot_pkg::AXIS_W-1:0]  r_ca, r_sa, r_cb, r_sb;
    logic        [EW-1:0]                 r_aw1, r_ah1, r_bw1, r_bh1;
    // stage 2
    logic signed [XW-1:0] r_pcc, r_pss, r_pcs, r_psc;
    logic signed [PW-1:0] r_ca_dx, r_sa_dy, r_sa_dx, r_ca_dy;
    logic signed [PW-1:0] r_cb_dx, r_sb_dy, r_sb_dx, r_cb_dy;
    logic        [EW-1:0] r_aw2, r_ah2, r_bw2, r_bh2;
    // stage 3
    logic [obbot_pkg::ABS_W-1:0] r_cc, r_sc;
    logic [AW-1:0]               r_d_ad, r_d_ap, r_d_bd, r_d_bp;
    logic [EW-1:0]               r_aw3, r_ah3, r_bw3, r_bh3;

    logic signed [DW-1:0]                     n_dx, n_dy;
    logic signed [obbot_pkg::DOT_W-1:0]       n_c1, n_s1;
    logic signed [SW-1:0]                     n_sad, n_sap, n_sbd, n_sbp;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_comb begin
        n_dx  = DW'(i_b_cx) - DW'(i_a_cx);
        n_dy  = DW'(i_b_cy) - DW'(i_a_cy);
        n_c1  = obbot_pkg::DOT_W'(r_pcc) + obbot_pkg::DOT_W'(r_pss);
        n_s1  = obbot_pkg::DOT_W'(r_psc) - obbot_pkg::DOT_W'(r_pcs);
        n_sad = SW'(r_ca_dx) + SW'(r_sa_dy);
        n_sap = SW'(r_ca_dy) - SW'(r_sa_dx);
        n_sbd = SW'(r_cb_dx) + SW'(r_sb_dy);
        n_sbp = SW'(r_cb_dy) - SW'(r_sb_dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_ca  <= i_a_cos;
            r_sa  <= i_a_sin;
            r_cb  <= i_b_cos;
            r_sb  <= i_b_sin;
            r_aw1 <= i_a_w;
            r_ah1 <= i_a_h;
            r_bw1 <= i_b_w;
            r_bh1 <= i_b_h;
        end
        if (en2) begin
            r_pcc   <= XW'(r_ca * r_cb);
            r_pss   <= XW'(r_sa * r_sb);
            r_pcs   <= XW'(r_ca * r_sb);
            r_psc   <= XW'(r_sa * r_cb);
            r_ca_dx <= PW'(r_ca * r_dx);
            r_sa_dy <= PW'(r_sa * r_dy);
            r_sa_dx <= PW'(r_sa * r_dx);
            r_ca_dy <= PW'(r_ca * r_dy);
            r_cb_dx <= PW'(r_cb * r_dx);
            r_sb_dy <= PW'(r_sb * r_dy);
            r_sb_dx <= PW'(r_sb * r_dx);
            r_cb_dy <= PW'(r_cb * r_dy);
            r_aw2   <= r_aw1;
            r_ah2   <= r_ah1;
            r_bw2   <= r_bw1;
            r_bh2   <= r_bh1;
        end
        if (en3) begin
            r_cc   <= n_c1[obbot_pkg::DOT_W-1] ? obbot_pkg::ABS_W'(-n_c1)
                                               : obbot_pkg::ABS_W'(n_c1);
            r_sc   <= n_s1[obbot_pkg::DOT_W-1] ? obbot_pkg::ABS_W'(-n_s1)
                                               : obbot_pkg::ABS_W'(n_s1);
            r_d_ad <= n_sad[SW-1] ? AW'(-n_sad) : AW'(n_sad);
            r_d_ap <= n_sap[SW-1] ? AW'(-n_sap) : AW'(n_sap);
            r_d_bd <= n_sbd[SW-1] ? AW'(-n_sbd) : AW'(n_sbd);
            r_d_bp <= n_sbp[SW-1] ? AW'(-n_sbp) : AW'(n_sbp);
            r_aw3  <= r_aw2;
            r_ah3  <= r_ah2;
            r_bw3  <= r_bw2;
            r_bh3  <= r_bh2;
        end
    end

    assign o_cc   = r_cc;
    assign o_sc   = r_sc;
    assign o_d_ad = r_d_ad;
    assign o_d_ap = r_d_ap;
    assign o_d_bd = r_d_bd;
    assign o_d_bp = r_d_bp;
    assign o_a_w  = r_aw3;
    assign o_a_h  = r_ah3;
    assign o_b_w  = r_bw3;
    assign o_b_h  = r_bh3;

endmodule

@@ rtl/core/obbot_sep.sv @@
// Last three pipeline stages: projected radii, interval bounds, axis compare.
// Depends on obbot_pkg; fed by obbot_proj.
module obbot_sep #(
    parameter int COORD_BITS = obbot_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic        [obbot_pkg::ABS_W-1:0] i_cc,
    input  logic        [obbot_pkg::ABS_W-1:0] i_sc,
    input  logic        [COORD_BITS+16:0]      i_d_ad,
    input  logic        [COORD_BITS+16:0]      i_d_ap,
    input  logic        [COORD_BITS+16:0]      i_d_bd,
    input  logic        [COORD_BITS+16:0]      i_d_bp,
    input  logic        [obbot_pkg::EXT_W-1:0] i_a_w,
    input  logic        [obbot_pkg::EXT_W-1:0] i_a_h,
    input  logic        [obbot_pkg::EXT_W-1:0] i_b_w,
    input  logic        [obbot_pkg::EXT_W-1:0] i_b_h,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_overlap
);
    localparam int AW   = COORD_BITS + 17;
    localparam int EPW  = obbot_pkg::EP_W;
    localparam int EW   = obbot_pkg::EXT_W;
    localparam int LW   = AW + obbot_pkg::POS_SHIFT;
    localparam int RW   = EPW + 2;
    localparam int CMPW = (LW > RW) ? LW : RW;

    logic en4, en5, en6;
    logic r_v4, r_v5, r_v6;

    // stage 4: extent times axis dot, for the four axes
    logic [EPW-1:0] r_ad_w, r_ad_h, r_ap_w, r_ap_h;
    logic [EPW-1:0] r_bd_w, r_bd_h, r_bp_w, r_bp_h;
    logic [AW-1:0]  r_d_ad4, r_d_ap4, r_d_bd4, r_d_bp4;
    logic [EW-1:0]  r_aw4, r_ah4, r_bw4, r_bh4;
    // stage 5: both sides of each axis compare
    logic [CMPW-1:0] r_lhs_ad, r_lhs_ap, r_lhs_bd, r_lhs_bp;
    logic [CMPW-1:0] r_rhs_ad, r_rhs_ap, r_rhs_bd, r_rhs_bp;
    // stage 6
    logic            r_overlap;

    logic n_sep;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v6;
    assign o_overlap = r_overlap;

    // an axis separates when |center offset| exceeds the sum of both radii
    assign n_sep = (r_lhs_ad > r_rhs_ad) || (r_lhs_ap > r_rhs_ap) ||
                   (r_lhs_bd > r_rhs_bd) || (r_lhs_bp > r_rhs_bp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            // axes of A span box B; axes of B span box A
            r_ad_w  <= EPW'(i_b_w) * EPW'(i_cc);
            r_ad_h  <= EPW'(i_b_h) * EPW'(i_sc);
            r_ap_w  <= EPW'(i_b_w) * EPW'(i_sc);
            r_ap_h  <= EPW'(i_b_h) * EPW'(i_cc);
            r_bd_w  <= EPW'(i_a_w) * EPW'(i_cc);
            r_bd_h  <= EPW'(i_a_h) * EPW'(i_sc);
            r_bp_w  <= EPW'(i_a_w) * EPW'(i_sc);
            r_bp_h  <= EPW'(i_a_h) * EPW'(i_cc);
            r_d_ad4 <= i_d_ad;
            r_d_ap4 <= i_d_ap;
            r_d_bd4 <= i_d_bd;
            r_d_bp4 <= i_d_bp;
            r_aw4   <= i_a_w;
            r_ah4   <= i_a_h;
            r_bw4   <= i_b_w;
            r_bh4   <= i_b_h;
        end
        if (en5) begin
            r_lhs_ad <= CMPW'(r_d_ad4) << obbot_pkg::POS_SHIFT;
            r_lhs_ap <= CMPW'(r_d_ap4) << obbot_pkg::POS_SHIFT;
            r_lhs_bd <= CMPW'(r_d_bd4) << obbot_pkg::POS_SHIFT;
            r_lhs_bp <= CMPW'(r_d_bp4) << obbot_pkg::POS_SHIFT;
            r_rhs_ad <= CMPW'(r_ad_w) + CMPW'(r_ad_h)
                        + (CMPW'(r_aw4) << obbot_pkg::HALF_SHIFT);
            r_rhs_ap <= CMPW'(r_ap_w) + CMPW'(r_ap_h)
                        + (CMPW'(r_ah4) << obbot_pkg::HALF_SHIFT);
            r_rhs_bd <= CMPW'(r_bd_w) + CMPW'(r_bd_h)
                        + (CMPW'(r_bw4) << obbot_pkg::HALF_SHIFT);
            r_rhs_bp <= CMPW'(r_bp_w) + CMPW'(r_bp_h)
                        + (CMPW'(r_bh4) << obbot_pkg::HALF_SHIFT);
        end
        if (en6) begin
            r_overlap <= !n_sep;
        end
    end

`ifndef ASSERT_OFF
    // refusing a request means every stage is full and the output is stalled
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v4 && r_v5 && r_v6 && !i_ready))
        else $error("sep stage blocks input with room in the pipeline");

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("sep output valid right after reset");

    // coincident centers never separate
    a_same_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && en6 && r_lhs_ad == '0 && r_lhs_ap == '0 && r_lhs_bd == '0
         && r_lhs_bp == '0) |=> r_overlap)
        else $error("separation reported for boxes with a common center");
`endif

endmodule
